// ===== hdl/iucb_pkg.sv =====
// Shared types and constants for the IPv4/UDP checksum builder.
// No dependencies; every other file in hdl/ uses this package.
package iucb_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 65507;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [7:0]  IP_VER_IHL      = 8'h45;
   localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
   localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;
   localparam logic [15:0] IP_HDR_BYTES    = 16'd20;

   localparam logic [7:0]  TTL_RESET   = 8'd255;
   localparam logic [7:0]  TOS_RESET   = 8'd0;
   localparam logic [15:0] IDENT_RESET = 16'd0;

   typedef enum logic [1:0] {
      CSR_TIME_TO_LIVE   = 2'd0,
      CSR_TYPE_OF_SERVICE = 2'd1,
      CSR_IDENT_VALUE    = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_HEADER  = 1'b0,
      REQ_PAYLOAD = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
      logic        last;
   } iucb_req_type;

   typedef struct packed {
      logic [15:0] ip_checksum;
      logic [15:0] udp_checksum;
      logic [15:0] ip_total_length;
      logic [15:0] udp_length;
      logic        length_error;
   } iucb_rsp_type;

   typedef struct packed {
      logic [7:0]  time_to_live;
      logic [7:0]  type_of_service;
      logic [15:0] ident_value;
   } iucb_cfg_type;

   // packet state captured on the last beat
   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] held_length;
      logic [15:0] running_sum;
      logic        odd_phase;
      logic [7:0]  pending_byte;
      logic [15:0] bytes_seen;
   } iucb_snap_type;

endpackage

// ===== hdl/iucb_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on iucb_pkg for the payload structs.
interface iucb_req_if;
   logic                 valid;
   logic                 ready;
   iucb_pkg::iucb_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface iucb_rsp_if;
   logic                 valid;
   logic                 ready;
   iucb_pkg::iucb_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ipv4_udp_checksum_builder_top.sv =====
// Channel    Dir  Beat contents
// req_chan   in   header (addresses, ports, length) or one payload byte, last flag
// rsp_chan   out  IP checksum, UDP checksum, both lengths, length error
// csr_*      in   TTL, TOS, identification writes
// One beat per cycle in while req_chan ready is high; a last beat is snapshotted,
// then the result is registered. The accumulator adds a word every second byte.
// Sync reset clears accumulator state and valid flags; config returns to defaults.
// A stalled result holds the snapshot stage; req_chan ready drops only when both
// the snapshot and result registers are full and the result is not being taken.
module ipv4_udp_checksum_builder_top #(
   parameter int unsigned MAX_PAYLOAD = iucb_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   iucb_req_if.sink    req_chan,
   iucb_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import iucb_pkg::*;

   iucb_cfg_type  cfg;
   iucb_snap_type snap;
   logic          snap_valid;
   logic          snap_ready;

   iucb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   iucb_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   iucb_sum #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_sum (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .cfg        (cfg),
      .rsp_chan   (rsp_chan)
   );
endmodule

// ===== hdl/iucb_csr.sv =====
// Configuration registers: TTL, TOS and identification field.
// Depends on iucb_pkg.
module iucb_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data,
   output iucb_pkg::iucb_cfg_type cfg
);
   import iucb_pkg::*;

   iucb_cfg_type cfg_ff;
   iucb_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TIME_TO_LIVE:    cfg_in.time_to_live    = csr_write_data[7:0];
            CSR_TYPE_OF_SERVICE: cfg_in.type_of_service = csr_write_data[7:0];
            CSR_IDENT_VALUE:     cfg_in.ident_value     = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_to_live    <= TTL_RESET;
         cfg_ff.type_of_service <= TOS_RESET;
         cfg_ff.ident_value     <= IDENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   a_ident_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && csr_index == CSR_IDENT_VALUE
      |=> cfg_ff.ident_value == $past(csr_write_data))
      else $error("ident register not written");

   a_no_write_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_enable |=> $stable(cfg_ff))
      else $error("config changed without a write");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && csr_index != CSR_TIME_TO_LIVE
      && csr_index != CSR_TYPE_OF_SERVICE && csr_index != CSR_IDENT_VALUE
      |=> $stable(cfg_ff))
      else $error("write to unused index changed config");
endmodule

// ===== hdl/iucb_accum.sv =====
// Packet state: latches header fields, pairs payload bytes into words and
// keeps the folded one's-complement sum; captures a snapshot on the last beat.
// Depends on iucb_pkg and iucb_if.
module iucb_accum (
   input  logic                  clock,
   input  logic                  reset,
   iucb_req_if.sink              req_chan,
   output logic                  snap_valid,
   input  logic                  snap_ready,
   output iucb_pkg::iucb_snap_type snap
);
   import iucb_pkg::*;

   iucb_snap_type state_ff;
   iucb_snap_type state_in;
   iucb_snap_type snap_ff;
   logic          snap_valid_ff;
   logic          accept;
   logic [16:0]   word_sum;

   assign req_chan.ready = !snap_valid_ff || snap_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign word_sum = 17'(state_ff.running_sum)
                   + 17'({state_ff.pending_byte, req_chan.data.data_byte});

   always_comb begin
      state_in = state_ff;
      if (req_chan.data.req_type == REQ_HEADER) begin
         state_in.src_ip       = req_chan.data.src_ip;
         state_in.dst_ip       = req_chan.data.dst_ip;
         state_in.src_port     = req_chan.data.src_port;
         state_in.dst_port     = req_chan.data.dst_port;
         state_in.held_length  = req_chan.data.payload_len;
         state_in.running_sum  = '0;
         state_in.odd_phase    = 1'b0;
         state_in.pending_byte = '0;
         state_in.bytes_seen   = '0;
      end else begin
         if (!state_ff.odd_phase) begin
            state_in.pending_byte = req_chan.data.data_byte;
            state_in.odd_phase    = 1'b1;
         end else begin
            state_in.running_sum = word_sum[15:0] + 16'(word_sum[16]);
            state_in.odd_phase   = 1'b0;
         end
         if (state_ff.bytes_seen != 16'hFFFF) begin
            state_in.bytes_seen = state_ff.bytes_seen + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && req_chan.data.last) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
      end
      if (accept && req_chan.data.last) begin
         snap_ff <= state_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.data.req_type == REQ_HEADER
      |=> state_ff.bytes_seen == 16'd0 && !state_ff.odd_phase
          && state_ff.running_sum == 16'd0)
      else $error("header beat did not clear packet state");

   a_phase_toggles: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.data.req_type == REQ_PAYLOAD
      |=> state_ff.odd_phase != $past(state_ff.odd_phase))
      else $error("byte pairing phase did not toggle");

   a_last_snaps: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.data.last |=> snap_valid_ff)
      else $error("last beat produced no snapshot");

   a_odd_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_seen != 16'hFFFF |-> state_ff.odd_phase == state_ff.bytes_seen[0])
      else $error("pairing phase disagrees with byte count");
endmodule

// ===== hdl/iucb_sum.sv =====
// Checksum and length stage: folds header, pseudo-header and data words of
// the snapshot into the result register. Depends on iucb_pkg and iucb_if.
module iucb_sum #(
   parameter int unsigned MAX_PAYLOAD = iucb_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_valid,
   output logic                   snap_ready,
   input  iucb_pkg::iucb_snap_type snap,
   input  iucb_pkg::iucb_cfg_type  cfg,
   iucb_rsp_if.source             rsp_chan
);
   import iucb_pkg::*;

   localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

   logic          out_valid_ff;
   iucb_rsp_type  out_ff;
   iucb_rsp_type  out_in;
   logic          over_max;
   logic [15:0]   eff_len;
   logic [15:0]   udp_len;
   logic [15:0]   ip_len;
   logic [15:0]   pad_word;
   logic [18:0]   ip_sum;
   logic [16:0]   ip_f1;
   logic [15:0]   ip_fold;
   logic [19:0]   udp_sum;
   logic [16:0]   udp_f1;
   logic [15:0]   udp_fold;

   assign snap_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      over_max = snap.held_length > MaxLen;
      eff_len  = over_max ? MaxLen : snap.held_length;
      udp_len  = eff_len + UDP_HDR_BYTES;
      ip_len   = eff_len + IP_UDP_HDR_BYTES;
      pad_word = snap.odd_phase ? {snap.pending_byte, 8'h00} : 16'h0000;

      ip_sum = 19'({IP_VER_IHL, cfg.type_of_service}) + 19'(ip_len)
             + 19'(cfg.ident_value) + 19'({cfg.time_to_live, PROTO_UDP})
             + 19'(snap.src_ip[31:16]) + 19'(snap.src_ip[15:0])
             + 19'(snap.dst_ip[31:16]) + 19'(snap.dst_ip[15:0]);
      ip_f1   = 17'(ip_sum[15:0]) + 17'(ip_sum[18:16]);
      ip_fold = ip_f1[15:0] + 16'(ip_f1[16]);

      udp_sum = 20'(snap.running_sum) + 20'(pad_word)
              + 20'(snap.src_ip[31:16]) + 20'(snap.src_ip[15:0])
              + 20'(snap.dst_ip[31:16]) + 20'(snap.dst_ip[15:0])
              + 20'(PROTO_UDP) + 20'(udp_len) + 20'(udp_len)
              + 20'(snap.src_port) + 20'(snap.dst_port);
      udp_f1   = 17'(udp_sum[15:0]) + 17'(udp_sum[19:16]);
      udp_fold = udp_f1[15:0] + 16'(udp_f1[16]);

      out_in.ip_checksum     = ~ip_fold;
      out_in.udp_checksum    = ~udp_fold;
      out_in.ip_total_length = ip_len;
      out_in.udp_length      = udp_len;
      out_in.length_error    = over_max || (snap.bytes_seen != snap.held_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         out_valid_ff <= snap_valid;
      end
      if (snap_ready && snap_valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   a_len_pair: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.ip_total_length == out_ff.udp_length + IP_HDR_BYTES)
      else $error("IP and UDP lengths disagree");

   a_len_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.udp_length >= UDP_HDR_BYTES)
      else $error("UDP length below header size");

   a_take: assert property (@(posedge clock) disable iff (reset)
      snap_valid && snap_ready |=> out_valid_ff)
      else $error("snapshot taken but no result registered");
endmodule
